@@ rtl/path_name_validator_core_defines.svh @@
// assertion macros for the path name validator checker
`ifndef PATH_NAME_VALIDATOR_CORE_DEFINES_SVH
`define PATH_NAME_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define PNV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define PNV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also runs during reset
`define PNV_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pnv_pkg.sv @@
// types, character codes and helper functions of the path name validator
package pnv_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7a;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5a;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;

    // segment length only matters as 0, 1, 2 or more
    localparam int unsigned SEG_W = 2;
    localparam logic [SEG_W-1:0] SEG_SAT = '1;

    // classification queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic is_slash;
        logic is_dot;
        logic bad;
        logic last;
    } t_cls;

    function automatic logic allowed_char(input logic [7:0] ch);
        allowed_char = ch inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z],
                                  [CH_DIG_0:CH_DIG_9], CH_DOT, CH_USCORE, CH_DASH};
    endfunction

    // a closing segment is bad if empty or "." or ".."
    function automatic logic close_bad(input logic [SEG_W-1:0] len, input logic dots);
        close_bad = (len == '0) || (dots && (len <= SEG_W'(2)));
    endfunction

endpackage

@@ rtl/pnv_front.sv @@
// front stage: takes characters and classifies them into queue words
module pnv_front (
    input  logic         i_push,
    input  logic [7:0]   i_ch,
    input  logic         i_last,
    output logic         o_full,
    input  logic         i_q_full,
    output logic         o_q_wr,
    output pnv_pkg::t_cls o_q_wdata
);
    import pnv_pkg::*;

    assign o_full             = i_q_full;
    assign o_q_wr             = i_push && !i_q_full;
    assign o_q_wdata.is_slash = (i_ch == CH_SLASH);
    assign o_q_wdata.is_dot   = (i_ch == CH_DOT);
    assign o_q_wdata.bad      = (i_ch != CH_SLASH) && !allowed_char(i_ch);
    assign o_q_wdata.last     = i_last;

endmodule

@@ rtl/pnv_queue.sv @@
// short queue of classified characters between front and back
module pnv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  pnv_pkg::t_cls i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_empty,
    output pnv_pkg::t_cls o_rdata
);
    import pnv_pkg::*;

    t_cls             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [Q_AW:0]    r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/pnv_back.sv @@
// back stage: name state update and result register
module pnv_back #(
    parameter int NAME_MAX = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  pnv_pkg::t_cls i_cls,
    output logic          o_q_rd,
    output logic          o_empty,
    input  logic          i_pop,
    output logic          o_valid_res
);
    import pnv_pkg::*;

    localparam int unsigned CNT_W = $clog2(NAME_MAX + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NAME_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(NAME_MAX);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SEG_W-1:0] r_len, n_len;
    logic             r_dots, n_dots;
    logic             r_err, n_err;
    logic             r_out_vld;
    logic             r_res;
    logic             take;
    logic             first;
    logic             fin_ok;

    assign take   = !i_q_empty && (!i_cls.last || !r_out_vld || i_pop);
    assign o_q_rd = take;
    assign first  = (r_cnt == '0);

    always_comb begin
        n_cnt  = r_cnt;
        n_len  = r_len;
        n_dots = r_dots;
        n_err  = r_err;
        if (i_cls.is_slash) begin
            if (!first) begin
                n_err  = r_err | close_bad(r_len, r_dots);
                n_len  = '0;
                n_dots = 1'b1;
            end
        end else begin
            n_err  = r_err | i_cls.bad;
            n_dots = r_dots & i_cls.is_dot;
            if (r_len != SEG_SAT) begin
                n_len = r_len + 1'b1;
            end
        end
        if (r_cnt < CNT_MAX) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign fin_ok = !(n_err || close_bad(n_len, n_dots) || (n_cnt > CNT_LIM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_len  <= '0;
            r_dots <= 1'b1;
            r_err  <= 1'b0;
        end else if (take) begin
            if (i_cls.last) begin
                r_cnt  <= '0;
                r_len  <= '0;
                r_dots <= 1'b1;
                r_err  <= 1'b0;
            end else begin
                r_cnt  <= n_cnt;
                r_len  <= n_len;
                r_dots <= n_dots;
                r_err  <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take && i_cls.last) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cls.last) begin
            r_res <= fin_ok;
        end
    end

    assign o_empty     = !r_out_vld;
    assign o_valid_res = r_res;

endmodule

@@ rtl/path_name_validator_core.sv @@
// top level of the path name validator: front, queue and back stage
// Checks a file name given one character per word (last marks its final
// character) and returns one word after the last character: valid_res is 1
// if the name has 1 to NAME_MAX characters, an optional leading slash,
// non-empty segments that are neither "." nor "..", and only letters,
// digits, dot, underscore and hyphen. One character is taken every cycle
// while the two-entry character queue has room; the back stage retires one
// character a cycle while the queue holds one. The last character is
// written into the queue when pushed, the verdict is registered when the
// back stage takes that character, and it sits in one result
// register; while it waits to be popped, non-final characters of the next
// name still flow, and only a final character stalls in the queue.
module path_name_validator_core #(
    parameter int NAME_MAX = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic       o_valid_res
);
    import pnv_pkg::*;

    // queue write side from the front
    logic q_wr;
    t_cls q_wdata;
    logic q_full;
    // queue read side to the back
    logic q_rd;
    logic q_empty;
    t_cls q_rdata;

    // front: classify each character as slash, dot or illegal byte
    pnv_front u_front (
        .i_push    (push),
        .i_ch      (i_ch),
        .i_last    (i_last),
        .o_full    (full),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr),
        .o_q_wdata (q_wdata)
    );

    // decoupling queue, lets the front keep taking words while the back waits
    pnv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    // back: segment and length tracking, verdict on the final character
    pnv_back #(
        .NAME_MAX (NAME_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cls       (q_rdata),
        .o_q_rd      (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_valid_res (o_valid_res)
    );

endmodule

@@ rtl/pnv_checker.sv @@
// port-level checker of the path name validator and its bind
`include "path_name_validator_core_defines.svh"

module pnv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_valid_res
);

    // reset leaves both sides empty and ready
    `PNV_ASSERT_ALWAYS_NXT(a_reset_clear, i_clk, !i_rst_n, empty && !full, "not idle after reset")

    // the queue only fills on an accepted word
    `PNV_ASSERT_IMP(a_full_on_push, i_clk, i_rst_n, $rose(full), $past(push && !full), "full rose without push")

    // a waiting result holds until popped
    `PNV_ASSERT_NXT(a_result_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_valid_res), "result lost")

    // with no result waiting, the queue not full and no word pushed just before, no result appears the next cycle
    `PNV_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, empty && !full && $past(empty && !full && !push), empty, "result without name")

endmodule

bind path_name_validator_core pnv_checker u_pnv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_valid_res (o_valid_res)
);

@@ dv/tb_path_name_validator_core.sv @@
// testbench for path_name_validator_core: streams of names, checked against a predictor
module tb_path_name_validator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pnv_pkg::*;

    localparam int NAME_MAX       = 63;
    localparam int SEG_LEN_SAT    = 127;
    // cycles with no word moving on either side before the run is called dead;
    // covers the long receiver hold-off plus the worst random gaps many times over
    localparam int WATCHDOG_LIMIT = 4000;
    // cycles to linger once nothing is expected
    localparam int TAIL_CYCLES    = 8;

    // dut ports; the inputs are known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    logic [7:0] i_ch        = 8'h00;
    logic       i_last      = 1'b0;
    logic       empty;
    logic       pop         = 1'b0;
    logic       o_valid_res;

    // idling percentages per cycle, and a receiver hold-off the receiver counts down
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned pop_hold_cycles = 0;

    int unsigned err_count      = 0;
    int unsigned chars_accepted = 0;

    // name being sent, one byte per entry
    logic [7:0] name_buf[$];

    // expected verdicts, oldest first, one per completed name
    logic verdict_q[$];

    // predictor state for the name in flight
    logic [6:0] name_len;
    logic [6:0] seg_len;
    logic       seg_only_dots;
    logic       name_bad;

    path_name_validator_core #(
        .NAME_MAX(NAME_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_ch       (i_ch),
        .i_last     (i_last),
        .empty      (empty),
        .pop        (pop),
        .o_valid_res(o_valid_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_name_state();
        name_len      = '0;
        seg_len       = '0;
        seg_only_dots = 1'b1;
        name_bad      = 1'b0;
    endfunction

    function automatic logic legal_name_char(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
               (c >= CH_DIG_0 && c <= CH_DIG_9) ||
               c == CH_DOT || c == CH_USCORE || c == CH_DASH;
    endfunction

    // a segment ends: empty, "." and ".." spoil the name
    function automatic void end_segment();
        if (seg_len == 0 || (seg_only_dots && seg_len <= 7'd2))
            name_bad = 1'b1;
        seg_len       = '0;
        seg_only_dots = 1'b1;
    endfunction

    // advance the name state by one accepted character; a final one yields a verdict
    function automatic void judge_char(input logic [7:0] c, input logic fin);
        logic opening;
        opening = (name_len == 0);
        if (c == CH_SLASH) begin
            // a leading slash opens the first segment instead of closing an empty one
            if (!opening)
                end_segment();
        end else begin
            if (!legal_name_char(c))
                name_bad = 1'b1;
            if (c != CH_DOT)
                seg_only_dots = 1'b0;
            if (seg_len != 7'(SEG_LEN_SAT))
                seg_len = seg_len + 7'd1;
        end
        // count saturates one past the limit so it never wraps
        if (name_len <= 7'(NAME_MAX))
            name_len = name_len + 7'd1;
        if (fin) begin
            end_segment();
            if (name_len > 7'(NAME_MAX))
                name_bad = 1'b1;
            verdict_q.push_back(!name_bad);
            clear_name_state();
        end
    endfunction

    initial clear_name_state();

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // receiver: checks each popped word against the oldest verdict, then picks the
    // next pop, honoring any hold-off and the random idle rate
    initial begin
        logic want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("valid_res %0b popped with none expected",
                                              o_valid_res));
                end else begin
                    want = verdict_q.pop_front();
                    if (o_valid_res !== want)
                        report_mismatch($sformatf("valid_res got %0b want %0b",
                                                  o_valid_res, want));
                end
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (pop_hold_cycles != 0) begin
                pop_hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: too long with no word moving on either side ends the run
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_path_name_validator_core failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one character; called right after a rising edge, returns right after the
    // edge that took it. push stays high so back-to-back words never drop it
    task automatic send_char(input logic [7:0] c, input logic fin);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_ch   <= c;
        i_last <= fin;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        judge_char(c, fin);
        chars_accepted++;
    endtask

    task automatic send_name();
        for (int i = 0; i < name_buf.size(); i++)
            send_char(name_buf[i], i == name_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
        send_name();
    endtask

    task automatic send_repeated(input logic [7:0] c, input int n, input logic lead_slash);
        name_buf.delete();
        if (lead_slash)
            name_buf.push_back(CH_SLASH);
        for (int i = 0; i < n; i++)
            name_buf.push_back(c);
        send_name();
    endtask

    // sender stops and waits until every verdict owed has been popped
    task automatic wait_verdicts_drained();
        push <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_name_char();
        int unsigned r;
        r = $urandom_range(64);
        if (r < 26)
            return CH_LC_A + 8'(r);
        else if (r < 52)
            return CH_UC_A + 8'(r - 26);
        else if (r < 62)
            return CH_DIG_0 + 8'(r - 52);
        else if (r == 62)
            return CH_DOT;
        else if (r == 63)
            return CH_USCORE;
        else
            return CH_DASH;
    endfunction

    // mostly well-formed names with random content; about a fifth get broken
    task automatic make_random_name();
        int unsigned kind;
        int unsigned nseg;
        int unsigned seg_kind;
        int unsigned seg_n;
        int unsigned pos;
        kind = $urandom_range(99);
        name_buf.delete();
        if (kind >= 95) begin
            // pure noise: raw bytes and slashes
            seg_n = $urandom_range(1, 6);
            for (int i = 0; i < seg_n; i++)
                name_buf.push_back(($urandom_range(3) == 0) ? CH_SLASH
                                                            : 8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(1) != 0)
            name_buf.push_back(CH_SLASH);
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++) begin
            if (s != 0)
                name_buf.push_back(CH_SLASH);
            seg_kind = $urandom_range(99);
            if (seg_kind < 5) begin
                name_buf.push_back(CH_DOT);
            end else if (seg_kind < 10) begin
                name_buf.push_back(CH_DOT);
                name_buf.push_back(CH_DOT);
            end else if (seg_kind < 13) begin
                // three dots is a legal segment
                repeat (3) name_buf.push_back(CH_DOT);
            end else begin
                // long segments now and then push names across the length limit
                if (kind == 0)
                    seg_n = $urandom_range(120, 140);
                else if (kind < 7)
                    seg_n = $urandom_range(14, 40);
                else
                    seg_n = $urandom_range(1, 8);
                for (int i = 0; i < seg_n; i++)
                    name_buf.push_back(($urandom_range(9) == 0) ? CH_DOT : pick_name_char());
            end
        end
        if (kind >= 80) begin
            case (kind % 3)
                0: begin
                    // one bad byte somewhere
                    pos = $urandom_range(name_buf.size() - 1);
                    name_buf[pos] = 8'($urandom_range(255));
                end
                1: begin
                    // stray slash, often making an empty segment
                    pos = $urandom_range(name_buf.size());
                    name_buf.insert(pos, CH_SLASH);
                end
                default: begin
                    name_buf.push_back(CH_SLASH);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // short names for every segment and character rule and both byte extremes
    task automatic test_directed_names();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_text("a");
        send_text("/");
        send_text("/a");
        send_text("a/");
        send_text("a//b");
        send_text(".");
        send_text("..");
        send_text("...");
        send_text("-_Z9");
        name_buf = '{8'h00};
        send_name();
        name_buf = '{8'hff};
        send_name();
    endtask

    // right at, just past and far past the limit, with and without a leading slash
    task automatic test_length_limit();
        send_repeated(CH_LC_A, NAME_MAX, 1'b0);
        send_repeated(CH_UC_Z, NAME_MAX + 1, 1'b0);
        send_repeated(CH_DIG_0, NAME_MAX - 1, 1'b1);
        send_repeated(CH_DASH, NAME_MAX, 1'b1);
        // segment long enough to saturate its own count
        send_repeated(CH_USCORE, 130, 1'b0);
    endtask

    task automatic test_random_names(input int unsigned n_chars, input int unsigned s_idle,
                                     input int unsigned r_idle);
        int unsigned start;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        start = chars_accepted;
        while (chars_accepted - start < n_chars) begin
            make_random_name();
            send_name();
        end
    endtask

    // receiver stops popping for a long stretch while short names keep coming,
    // so the result register and queue fill and full pushes back
    task automatic test_result_backpressure();
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        pop_hold_cycles = 300;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2)
                send_text("/x");
            else if (i[0])
                send_text(".");
            else
                send_text("ok");
        end
    endtask

    // sender goes quiet until all verdicts are out, then resumes
    task automatic test_drain_pause();
        send_idle_pct = 20;
        recv_idle_pct = 50;
        for (int i = 0; i < 6; i++) begin
            make_random_name();
            send_name();
        end
        wait_verdicts_drained();
        send_text("after/pause");
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_names();
        test_length_limit();
        test_random_names(400, 36, 76);
        test_random_names(400, 76, 36);
        test_result_backpressure();
        test_drain_pause();
        test_random_names(400, 0, 0);

        // all words sent; let the last verdicts out, then watch for strays
        wait_verdicts_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d verdicts never popped", verdict_q.size()));

        if (err_count == 0) begin
            $display("tb_path_name_validator_core passed");
        end else begin
            $display("tb_path_name_validator_core failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pnv_pkg.sv
rtl/pnv_front.sv
rtl/pnv_queue.sv
rtl/pnv_back.sv
rtl/path_name_validator_core.sv
rtl/pnv_checker.sv
dv/tb_path_name_validator_core.sv
